// File: rtl/assert_macros.svh
// assertion macros used by the checker file msp_checker.sv
// clocked on clk_i, reset by the active-low rst_ni of the bound module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define MSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every edge, reset included
`define MSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/msp_pkg.sv
// shared types and constants of the matrix saddle point finder
// no dependencies
`timescale 1ns / 1ps

package msp_pkg;

  localparam int DATA_W    = 32;
  localparam int ROW_CNT_W = 13;
  localparam int COL_CNT_W = 9;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_HW    = 4096;
  localparam int COL_HW    = 256;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] best;
    logic signed [DATA_W-1:0] least;
  } fin_t;

endpackage

// File: rtl/msp_cell.sv
// one column maximum cell of the rotating chain
// depends on msp_pkg
`timescale 1ns / 1ps

module msp_cell (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic                             is_tail_i,
  input  logic signed [msp_pkg::DATA_W-1:0] tail_i,
  input  logic signed [msp_pkg::DATA_W-1:0] nbr_i,
  output logic signed [msp_pkg::DATA_W-1:0] val_o
);
  import msp_pkg::*;

  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] val_d;

  assign val_d = is_tail_i ? tail_i : nbr_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// File: rtl/msp_out.sv
// final compare stage and output register of the saddle point finder
// depends on msp_pkg
`timescale 1ns / 1ps

module msp_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  msp_pkg::fin_t                    fin_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic                             found_o,
  output logic signed [msp_pkg::DATA_W-1:0] saddle_value_o,
  output logic                             full_o
);
  import msp_pkg::*;

  logic   p_valid_q, p_valid_d;
  fin_t   p_q;
  logic   o_valid_q, o_valid_d;
  logic   o_found_q;
  logic signed [DATA_W-1:0] o_value_q;
  logic   move;
  logic   hit;

  assign move = p_valid_q && (!o_valid_q || !out_stall_i);
  assign hit  = (p_q.best == p_q.least);

  always_comb begin
    p_valid_d = p_valid_q;
    if (move) begin
      p_valid_d = 1'b0;
    end
    if (load_i) begin
      p_valid_d = 1'b1;
    end
    o_valid_d = o_valid_q && out_stall_i;
    if (move) begin
      o_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q <= fin_i;
    end
    if (move) begin
      o_found_q <= hit;
      o_value_q <= hit ? p_q.best : '0;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign found_o        = o_found_q;
  assign saddle_value_o = o_value_q;
  assign full_o         = p_valid_q && o_valid_q && out_stall_i;

endmodule

// File: rtl/matrix_saddle_point_finder.sv
// after the last element, the result is registered in the compare stage, then in the output register
// throughput: one element per cycle while in_stall_o is low; each element shifts the column maximum chain once
// the input stalls only while the output is stalled with one result waiting there and a second in the compare stage
// reset clears positions, running values and counts to one row by one column
// column cells get no reset: the first row of each matrix writes every column
`timescale 1ns / 1ps

module matrix_saddle_point_finder #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [msp_pkg::DATA_W-1:0]  element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic signed [msp_pkg::DATA_W-1:0]  saddle_value_o
);
  import msp_pkg::*;

  localparam int COL_LIM = (MAX_COLS < COL_HW) ? MAX_COLS : COL_HW;
  localparam int ROW_LIM = (MAX_ROWS < ROW_HW) ? MAX_ROWS : ROW_HW;
  localparam int COL_W   = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
  localparam int ROW_W   = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;

  logic                     accept;
  logic                     full;
  logic [COL_W-1:0]         col_last_q, col_last_d;
  logic [ROW_W-1:0]         row_last_q, row_last_d;
  logic [COL_W-1:0]         col_pos_q, col_pos_d;
  logic [ROW_W-1:0]         row_pos_q, row_pos_d;
  logic signed [DATA_W-1:0] run_min_q, run_min_d;
  logic signed [DATA_W-1:0] best_q, best_d;
  logic signed [DATA_W-1:0] least_q, least_d;
  logic signed [DATA_W-1:0] run_min_new, best_new, least_new;
  logic signed [DATA_W-1:0] cm;
  logic signed [DATA_W-1:0] cell_val [COL_LIM];
  logic                     first_row, last_col, last_row, final_item;
  logic [ROW_CNT_W-1:0]     rc;
  logic [COL_CNT_W-1:0]     cc;
  logic                     cfg_hit;
  fin_t                     fin;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = full;

  assign first_row  = (row_pos_q == '0);
  assign last_col   = (col_pos_q == col_last_q);
  assign last_row   = (row_pos_q == row_last_q);
  assign final_item = last_col && last_row;

  assign cm = (first_row || (cell_val[0] < element_value_i)) ? element_value_i : cell_val[0];
  assign run_min_new = (element_value_i < run_min_q) ? element_value_i : run_min_q;
  assign best_new  = (last_col && (best_q < run_min_new)) ? run_min_new : best_q;
  assign least_new = (last_row && (cm < least_q)) ? cm : least_q;

  assign fin.best  = best_new;
  assign fin.least = least_new;

  // rotating chain of column maxima, head holds the current column
  for (genvar k = 0; k < COL_LIM; k++) begin : g_cell
    logic signed [DATA_W-1:0] nbr;
    if (k == COL_LIM - 1) begin : g_end
      assign nbr = cm;
    end else begin : g_mid
      assign nbr = cell_val[k+1];
    end
    msp_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (accept),
      .is_tail_i (col_last_q == COL_W'(k)),
      .tail_i    (cm),
      .nbr_i     (nbr),
      .val_o     (cell_val[k])
    );
  end

  assign rc = cfg_wdata_i[ROW_CNT_W-1:0];
  assign cc = cfg_wdata_i[COL_CNT_W-1:0];
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == REG_ROW_COUNT) || (cfg_idx_i == REG_COL_COUNT));

  always_comb begin
    row_last_d = row_last_q;
    col_last_d = col_last_q;
    row_pos_d  = row_pos_q;
    col_pos_d  = col_pos_q;
    run_min_d  = run_min_q;
    best_d     = best_q;
    least_d    = least_q;
    if (cfg_hit) begin
      if (cfg_idx_i == REG_ROW_COUNT) begin
        priority if (rc == '0) begin
          row_last_d = '0;
        end else if (rc > ROW_CNT_W'(ROW_LIM)) begin
          row_last_d = ROW_W'(ROW_LIM - 1);
        end else begin
          row_last_d = ROW_W'(rc - 1'b1);
        end
      end else begin
        priority if (cc == '0) begin
          col_last_d = '0;
        end else if (cc > COL_CNT_W'(COL_LIM)) begin
          col_last_d = COL_W'(COL_LIM - 1);
        end else begin
          col_last_d = COL_W'(cc - 1'b1);
        end
      end
      row_pos_d = '0;
      col_pos_d = '0;
      run_min_d = INT_MAX;
      best_d    = INT_MIN;
      least_d   = INT_MAX;
    end else if (accept) begin
      if (final_item) begin
        row_pos_d = '0;
        col_pos_d = '0;
        run_min_d = INT_MAX;
        best_d    = INT_MIN;
        least_d   = INT_MAX;
      end else begin
        best_d  = best_new;
        least_d = least_new;
        if (last_col) begin
          col_pos_d = '0;
          row_pos_d = row_pos_q + 1'b1;
          run_min_d = INT_MAX;
        end else begin
          col_pos_d = col_pos_q + 1'b1;
          run_min_d = run_min_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_last_q <= '0;
      col_last_q <= '0;
      row_pos_q  <= '0;
      col_pos_q  <= '0;
      run_min_q  <= INT_MAX;
      best_q     <= INT_MIN;
      least_q    <= INT_MAX;
    end else begin
      row_last_q <= row_last_d;
      col_last_q <= col_last_d;
      row_pos_q  <= row_pos_d;
      col_pos_q  <= col_pos_d;
      run_min_q  <= run_min_d;
      best_q     <= best_d;
      least_q    <= least_d;
    end
  end

  msp_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && final_item),
    .fin_i          (fin),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .found_o        (found_o),
    .saddle_value_o (saddle_value_o),
    .full_o         (full)
  );

endmodule

// File: rtl/msp_checker.sv
// port-level checks of the matrix saddle point finder, bound to the top level
// depends on msp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              found_o,
  input logic signed [msp_pkg::DATA_W-1:0] saddle_value_o
);
  import msp_pkg::*;

  `MSP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(saddle_value_o), "stalled item changed")
  `MSP_ASSERT(a_zero_miss, out_valid_o && !found_o |-> saddle_value_o == '0, "no saddle but value not zero")
  `MSP_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o, "input stalled with no item waiting")
  `MSP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o, "not idle in reset")

endmodule

bind matrix_saddle_point_finder msp_checker u_msp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .saddle_value_o (saddle_value_o)
);

// File: sim/matrix_saddle_point_finder_tb.sv
// testbench of the matrix saddle point finder: streams matrices, predicts each result and checks it
// depends on msp_pkg and matrix_saddle_point_finder
`timescale 1ns / 1ps

module matrix_saddle_point_finder_tb;
  import msp_pkg::*;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] value;
  } saddle_result_t;

  typedef enum int { MAT_SADDLE, MAT_RANDOM, MAT_EXTREME } matrix_kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam int HOLD_CYCLES      = 200;
  localparam int SETTLE_CYCLES    = 4;
  localparam int ITEMS_PER_MODE   = 180;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b1;
  logic                     cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i       = '0;
  logic [CFG_W-1:0]         cfg_wdata_i     = '0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] element_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic                     found_o;
  logic signed [DATA_W-1:0] saddle_value_o;

  matrix_saddle_point_finder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .saddle_value_o (saddle_value_o)
  );

  always #2 clk_i = ~clk_i;

  logic signed [DATA_W-1:0] pending_elements[$];
  saddle_result_t           expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_cnt  = 0;
  int accepted_cnt  = 0;
  int result_cnt    = 0;
  int saddle_cnt    = 0;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;
  int hold_cnt      = 0;

  // predictor state
  logic [ROW_CNT_W-1:0]     row_count_q   = ROW_CNT_W'(1);
  logic [COL_CNT_W-1:0]     col_count_q   = COL_CNT_W'(1);
  logic signed [DATA_W-1:0] col_max_mem [COL_HW];
  logic signed [DATA_W-1:0] row_min_run   = INT_MAX;
  logic signed [DATA_W-1:0] best_row_min  = INT_MIN;
  logic signed [DATA_W-1:0] least_col_max = INT_MAX;
  int unsigned              row_pos       = 0;
  int unsigned              col_pos       = 0;

  function automatic void queue_element(logic signed [DATA_W-1:0] v);
    pending_elements.insert(pending_elements.size(), v);
  endfunction

  function automatic void restart_matrix();
    row_min_run   = INT_MAX;
    best_row_min  = INT_MIN;
    least_col_max = INT_MAX;
    row_pos       = 0;
    col_pos       = 0;
  endfunction

  function automatic void apply_count_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == REG_ROW_COUNT) begin
      row_count_q = data[ROW_CNT_W-1:0];
      restart_matrix();
    end else if (idx == REG_COL_COUNT) begin
      col_count_q = data[COL_CNT_W-1:0];
      restart_matrix();
    end
  endfunction

  function automatic void predict_saddle(logic signed [DATA_W-1:0] v);
    int unsigned rows, cols, r, c;
    logic signed [DATA_W-1:0] cm;
    logic last_col, last_row;
    saddle_result_t res;
    rows = (row_count_q == 0) ? 1 : (row_count_q > ROW_HW) ? ROW_HW : row_count_q;
    cols = (col_count_q == 0) ? 1 : (col_count_q > COL_HW) ? COL_HW : col_count_q;
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    last_col = (c == cols - 1);
    last_row = (r == rows - 1);
    if (v < row_min_run) row_min_run = v;
    if (r == 0) begin
      cm = v;
    end else begin
      cm = col_max_mem[c];
      if (cm < v) cm = v;
    end
    col_max_mem[c] = cm;
    if (last_row && cm < least_col_max) least_col_max = cm;
    if (last_col) begin
      if (best_row_min < row_min_run) best_row_min = row_min_run;
      row_min_run = INT_MAX;
    end
    if (last_col && last_row) begin
      res.found = (best_row_min == least_col_max);
      res.value = res.found ? best_row_min : '0;
      expected_results.insert(expected_results.size(), res);
      restart_matrix();
    end else if (last_col) begin
      col_pos = 0;
      row_pos = (r + 1) & 32'hFFF;
    end else begin
      col_pos = (c + 1) & 32'hFF;
      row_pos = r;
    end
  endfunction

  // element driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) void'(pending_elements.pop_front());
      if (pending_elements.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i      <= 1'b1;
        element_value_i <= pending_elements[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic note_mismatch(string what, saddle_result_t want);
    if (mismatch_cnt < 10)
      $display("mismatch (%0s): expected found=%0b value=%0d, got found=%0b value=%0d",
               what, want.found, want.value, found_o, saddle_value_o);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_saddle(element_value_i);
      accepted_cnt++;
    end
  end

  always @(posedge clk_i) begin : check_result
    saddle_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (expected_results.size() == 0) begin
        want = '0;
        note_mismatch("unexpected result", want);
      end else begin
        want = expected_results.pop_front();
        if (want.found) saddle_cnt++;
        if (found_o !== want.found || saddle_value_o !== want.value)
          note_mismatch("wrong result", want);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    apply_count_write(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle_idle();
    do @(posedge clk_i);
    while (pending_elements.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_between(longint lo, longint hi);
    longint span;
    longint pick;
    span = hi - lo + 1;
    pick = longint'({$urandom, $urandom} >> 1) % span;
    return DATA_W'(lo + pick);
  endfunction

  task automatic push_matrix(int rows, int cols, matrix_kind_e kind);
    int sr, sc;
    logic signed [DATA_W-1:0] s, v;
    sr = $urandom_range(0, rows - 1);
    sc = $urandom_range(0, cols - 1);
    s  = rand_between(longint'(INT_MIN) + 1, longint'(INT_MAX) - 1);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        case (kind)
          MAT_SADDLE: begin
            // saddle cell is the minimum of its row and the maximum of its column
            if (r == sr && c == sc) v = s;
            else if (r == sr) v = rand_between(longint'(s) + 1, longint'(INT_MAX));
            else if (c == sc) v = rand_between(longint'(INT_MIN), longint'(s) - 1);
            else v = $urandom;
          end
          MAT_RANDOM: begin
            v = $urandom;
          end
          default: begin
            case ($urandom_range(0, 4))
              0: v = INT_MIN;
              1: v = INT_MAX;
              2: v = '0;
              3: v = -32'sd1;
              default: v = 32'sd1;
            endcase
          end
        endcase
        queue_element(v);
      end
    end
  endtask

  initial begin
    int rows, cols, mode_items, bursts, partial;
    logic [CFG_W-1:0] row_data, col_data;
    matrix_kind_e kind;
    saddle_result_t none;

    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: zero counts act as one, single elements at the extremes
    send_idle_pct = 11;
    recv_idle_pct = 77;
    write_reg(REG_ROW_COUNT, '0);
    write_reg(REG_COL_COUNT, '0);
    queue_element(INT_MIN);
    queue_element(INT_MAX);
    queue_element(32'sd0);
    queue_element(-32'sd1);
    settle_idle();

    // 2x2 with saddle, without saddle, all ties, back to back
    write_reg(REG_ROW_COUNT, CFG_W'(2));
    write_reg(REG_COL_COUNT, CFG_W'(2));
    queue_element(32'sd5);
    queue_element(32'sd9);
    queue_element(-32'sd3);
    queue_element(32'sd2);
    queue_element(32'sd1);
    queue_element(32'sd4);
    queue_element(32'sd3);
    queue_element(32'sd2);
    repeat (4) queue_element(INT_MAX);
    settle_idle();

    // unknown indexes ignored, column data above its width dropped
    write_reg(REG_UNUSED_2, CFG_W'(13'h1ABC));
    write_reg(REG_ROW_COUNT, CFG_W'(1));
    write_reg(REG_COL_COUNT, CFG_W'(13'h1E03));
    write_reg(REG_UNUSED_3, '1);
    queue_element(INT_MAX);
    queue_element(INT_MIN);
    queue_element(32'sd7);
    settle_idle();

    write_reg(REG_ROW_COUNT, CFG_W'(3));
    write_reg(REG_COL_COUNT, CFG_W'(1));
    queue_element(INT_MIN);
    queue_element(32'sd0);
    queue_element(INT_MAX);
    settle_idle();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 11; recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (mode == 2) begin
        // receiver holds off while 1x1 items keep coming, so the input backs up
        write_reg(REG_ROW_COUNT, CFG_W'(1));
        write_reg(REG_COL_COUNT, CFG_W'(1));
        hold_req <= 1'b1;
        repeat (30) queue_element($urandom);
        settle_idle();

        // column count above the supported size saturates
        write_reg(REG_ROW_COUNT, CFG_W'(1));
        write_reg(REG_COL_COUNT, CFG_W'(13'h01FF));
        push_matrix(1, COL_HW, MAT_EXTREME);
        settle_idle();
      end

      mode_items = 0;
      while (mode_items < ITEMS_PER_MODE) begin
        rows     = $urandom_range(1, 5);
        cols     = $urandom_range(1, 6);
        row_data = CFG_W'(rows);
        col_data = CFG_W'(cols | ($urandom_range(0, 15) << COL_CNT_W));
        if ($urandom_range(0, 19) == 0) begin
          row_data = '0;
          rows     = 1;
        end
        if ($urandom_range(0, 19) == 0) begin
          col_data = CFG_W'($urandom_range(0, 15) << COL_CNT_W);
          cols     = 1;
        end
        if ($urandom_range(0, 9) == 0)
          write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_W'($urandom));
        if ($urandom_range(0, 1)) begin
          write_reg(REG_ROW_COUNT, row_data);
          write_reg(REG_COL_COUNT, col_data);
        end else begin
          write_reg(REG_COL_COUNT, col_data);
          write_reg(REG_ROW_COUNT, row_data);
        end
        bursts = $urandom_range(1, 3);
        repeat (bursts) begin
          case ($urandom_range(0, 19))
            0, 1, 2: kind = MAT_EXTREME;
            3, 4, 5, 6, 7, 8: kind = MAT_RANDOM;
            default: kind = MAT_SADDLE;
          endcase
          push_matrix(rows, cols, kind);
          mode_items += rows * cols;
        end
        // cut-off matrix, abandoned by the next count write
        if ($urandom_range(0, 9) == 0 && rows * cols > 1) begin
          partial = $urandom_range(1, rows * cols - 1);
          repeat (partial) queue_element($urandom);
          mode_items += partial;
        end
        settle_idle();
      end
    end

    do @(posedge clk_i);
    while (pending_elements.size() != 0 || in_valid_i);
    for (int k = 0; k < 1000 && expected_results.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    none = '0;
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      note_mismatch("missing result", none);
    end

    $display("covered %0d elements and %0d matrix results (%0d with a saddle value)",
             accepted_cnt, result_cnt, saddle_cnt);
    $display("count settings from 1x1 up to a saturated 256 columns, %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: matrix_saddle_point_finder.f
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_cell.sv
rtl/msp_out.sv
rtl/matrix_saddle_point_finder.sv
rtl/msp_checker.sv
sim/matrix_saddle_point_finder_tb.sv
